// ===== src/quadratic_root_solver_defines.svh =====
// Assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Check a consequence in the same cycle
`define QRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the next cycle
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/qrs_pkg.sv =====
package qrs_pkg;

	localparam int SQ_STEPS  = 25;
	localparam int RAD_W     = 2 * SQ_STEPS;
	localparam int DIV_STEPS = 32;

	localparam logic [1:0] CASE_NONE      = 2'd0;
	localparam logic [1:0] CASE_DOUBLE    = 2'd1;
	localparam logic [1:0] CASE_DISTINCT  = 2'd2;
	localparam logic [1:0] CASE_LEAD_ZERO = 2'd3;

	localparam logic signed [31:0] ROOT_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] ROOT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [15:0] coef_quad;
		logic signed [15:0] coef_lin;
		logic signed [15:0] coef_const;
	} coef_t;

	typedef struct packed {
		logic signed [31:0] first_root;
		logic signed [31:0] second_root;
		logic [1:0]         root_case;
		logic               overflow;
	} root_t;

endpackage

// ===== src/quadratic_root_solver.sv =====
// Real roots of a*x^2+b*x+c from signed Q8.8 coefficients, as saturated Q16.16.
// One request enters per cycle unless the output stalls; it passes a product
// stage, a discriminant stage, 25 square-root stages (one root bit each), a
// numerator stage, 32 divide stages (one quotient bit each, both roots side by
// side) and the output register. The whole pipeline holds while a result is
// stalled at the output.
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                coef_valid,
	output logic                coef_stall,
	input  qrs_pkg::coef_t      coef,
	output logic                root_valid,
	input  logic                root_stall,
	output qrs_pkg::root_t      root
);

	logic adv;
	assign adv        = !root_valid || !root_stall;
	assign coef_stall = !adv;

	// products
	logic               v_s1;
	logic signed [15:0] a_s1, b_s1;
	logic signed [31:0] bb_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= coef_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1  <= coef.coef_quad;
			b_s1  <= coef.coef_lin;
			bb_s1 <= coef.coef_lin * coef.coef_lin;
			ac_s1 <= coef.coef_quad * coef.coef_const;
		end
	end

	// discriminant and class
	logic signed [33:0] disc;
	logic [1:0]         kind;
	assign disc = 34'(bb_s1) - (34'(ac_s1) <<< 2);

	always_comb begin
		if (a_s1 == 16'sd0) begin
			kind = qrs_pkg::CASE_LEAD_ZERO;
		end else if (disc < 34'sd0) begin
			kind = qrs_pkg::CASE_NONE;
		end else if (disc == 34'sd0) begin
			kind = qrs_pkg::CASE_DOUBLE;
		end else begin
			kind = qrs_pkg::CASE_DISTINCT;
		end
	end

	logic [qrs_pkg::SQ_STEPS:0]     sq_v_s;
	logic [qrs_pkg::RAD_W-1:0]      sq_rad_s  [0:qrs_pkg::SQ_STEPS];
	logic [26:0]                    sq_rem_s  [0:qrs_pkg::SQ_STEPS];
	logic [24:0]                    sq_root_s [0:qrs_pkg::SQ_STEPS];
	logic signed [15:0]             sq_a_s    [0:qrs_pkg::SQ_STEPS];
	logic signed [24:0]             sq_nb_s   [0:qrs_pkg::SQ_STEPS];
	logic [1:0]                     sq_kind_s [0:qrs_pkg::SQ_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (adv) begin
			sq_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rad_s[0]  <= (kind == qrs_pkg::CASE_DISTINCT) ?
				{1'b0, disc[32:0], 16'b0} : '0;
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_a_s[0]    <= a_s1;
			sq_nb_s[0]   <= 25'sd0 - $signed({b_s1[15], b_s1, 8'b0});
			sq_kind_s[0] <= kind;
		end
	end

	// square root, one bit per stage
	for (genvar k = 0; k < qrs_pkg::SQ_STEPS; k++) begin : g_sq
		logic [28:0] cur, trial;
		logic        take;
		assign cur   = {sq_rem_s[k], sq_rad_s[k][qrs_pkg::RAD_W-1 -: 2]};
		assign trial = {2'b0, sq_root_s[k], 2'b01};
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rad_s[k+1]  <= sq_rad_s[k] << 2;
				sq_rem_s[k+1]  <= take ? 27'(cur - trial) : 27'(cur);
				sq_root_s[k+1] <= {sq_root_s[k][23:0], take};
				sq_a_s[k+1]    <= sq_a_s[k];
				sq_nb_s[k+1]   <= sq_nb_s[k];
				sq_kind_s[k+1] <= sq_kind_s[k];
			end
		end
	end

	// numerators, split into sign and magnitude
	logic signed [26:0] num [0:1];
	logic [26:0]        num_mag [0:1];
	logic [15:0]        div_mag;
	assign num[0]  = 27'(sq_nb_s[qrs_pkg::SQ_STEPS]) -
		$signed({2'b0, sq_root_s[qrs_pkg::SQ_STEPS]});
	assign num[1]  = 27'(sq_nb_s[qrs_pkg::SQ_STEPS]) +
		$signed({2'b0, sq_root_s[qrs_pkg::SQ_STEPS]});
	assign num_mag[0] = num[0][26] ? 27'(-num[0]) : 27'(num[0]);
	assign num_mag[1] = num[1][26] ? 27'(-num[1]) : 27'(num[1]);
	assign div_mag = sq_a_s[qrs_pkg::SQ_STEPS][15] ?
		16'(-sq_a_s[qrs_pkg::SQ_STEPS]) : 16'(sq_a_s[qrs_pkg::SQ_STEPS]);

	logic [qrs_pkg::DIV_STEPS:0] dv_v_s;
	logic [31:0]                 dv_dvd_s  [0:qrs_pkg::DIV_STEPS][0:1];
	logic [15:0]                 dv_rem_s  [0:qrs_pkg::DIV_STEPS][0:1];
	logic [31:0]                 dv_q_s    [0:qrs_pkg::DIV_STEPS][0:1];
	logic [1:0]                  dv_neg_s  [0:qrs_pkg::DIV_STEPS];
	logic [15:0]                 dv_div_s  [0:qrs_pkg::DIV_STEPS];
	logic [1:0]                  dv_kind_s [0:qrs_pkg::DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= sq_v_s[qrs_pkg::SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				dv_dvd_s[0][l] <= {num_mag[l][24:0], 7'b0};
				dv_rem_s[0][l] <= '0;
				dv_q_s[0][l]   <= '0;
				dv_neg_s[0][l] <= num[l][26] ^ sq_a_s[qrs_pkg::SQ_STEPS][15];
			end
			dv_div_s[0]  <= div_mag;
			dv_kind_s[0] <= sq_kind_s[qrs_pkg::SQ_STEPS];
		end
	end

	// divide, one quotient bit per stage in each lane
	for (genvar j = 0; j < qrs_pkg::DIV_STEPS; j++) begin : g_dv
		logic [16:0] cur [0:1];
		logic [1:0]  take;
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				cur[l]  = {dv_rem_s[j][l], dv_dvd_s[j][l][31]};
				take[l] = cur[l] >= {1'b0, dv_div_s[j]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 2; l++) begin
					dv_dvd_s[j+1][l] <= dv_dvd_s[j][l] << 1;
					dv_rem_s[j+1][l] <= take[l] ? 16'(cur[l] - {1'b0, dv_div_s[j]}) :
						16'(cur[l]);
					dv_q_s[j+1][l]   <= {dv_q_s[j][l][30:0], take[l]};
				end
				dv_neg_s[j+1]  <= dv_neg_s[j];
				dv_div_s[j+1]  <= dv_div_s[j];
				dv_kind_s[j+1] <= dv_kind_s[j];
			end
		end
	end

	// sign, saturate and drop roots that do not exist
	logic signed [31:0] sat [0:1];
	logic [1:0]         sat_ovf;
	logic               roots_real;
	assign roots_real = dv_kind_s[qrs_pkg::DIV_STEPS] inside
		{qrs_pkg::CASE_DOUBLE, qrs_pkg::CASE_DISTINCT};

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (dv_neg_s[qrs_pkg::DIV_STEPS][l]) begin
				sat_ovf[l] = dv_q_s[qrs_pkg::DIV_STEPS][l] > 32'h8000_0000;
				sat[l]     = sat_ovf[l] ? qrs_pkg::ROOT_MIN :
					$signed(32'(32'd0 - dv_q_s[qrs_pkg::DIV_STEPS][l]));
			end else begin
				sat_ovf[l] = dv_q_s[qrs_pkg::DIV_STEPS][l][31];
				sat[l]     = sat_ovf[l] ? qrs_pkg::ROOT_MAX :
					$signed(dv_q_s[qrs_pkg::DIV_STEPS][l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid <= 1'b0;
		end else if (adv) begin
			root_valid <= dv_v_s[qrs_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root.first_root  <= roots_real ? sat[0] : 32'sd0;
			root.second_root <= roots_real ? sat[1] : 32'sd0;
			root.root_case   <= dv_kind_s[qrs_pkg::DIV_STEPS];
			root.overflow    <= roots_real && (sat_ovf != 2'b00);
		end
	end

	logic roots_absent, roots_zero, double_out;
	assign roots_absent = root_valid &&
		(root.root_case inside {qrs_pkg::CASE_NONE, qrs_pkg::CASE_LEAD_ZERO});
	assign roots_zero   = root.first_root == 32'sd0 && root.second_root == 32'sd0 &&
		!root.overflow;
	assign double_out   = root_valid && root.root_case == qrs_pkg::CASE_DOUBLE;

	`QRS_ASSERT_NOW(a_no_roots_zero, roots_absent, roots_zero, "missing roots not zero")
	`QRS_ASSERT_NOW(a_double_equal, double_out, root.first_root == root.second_root, "double root differs")
	`QRS_ASSERT_NEXT(a_hold_pipe, !adv, $stable(sq_v_s) && $stable(dv_v_s), "pipeline moved while held")

endmodule

// ===== tb/quadratic_root_solver_tb.sv =====
`timescale 1ns / 100ps

module quadratic_root_solver_tb;

	logic            clk;
	logic            arst_n;
	logic            coef_valid;
	logic            coef_stall;
	qrs_pkg::coef_t  coef;
	logic            root_valid;
	logic            root_stall;
	qrs_pkg::root_t  root;

	qrs_pkg::root_t  roots_due[$];
	int     mismatches;
	bit     quiet;
	bit     hold_off;
	int     hold_cycles;

	quadratic_root_solver uut (
		.clk(clk), .arst_n(arst_n),
		.coef_valid(coef_valid), .coef_stall(coef_stall), .coef(coef),
		.root_valid(root_valid), .root_stall(root_stall), .root(root)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] clamp_root(longint num, longint a, ref logic ovf);
		longint q;
		q = (num * 128) / a;
		if (q > 64'sd2147483647) begin
			ovf = 1'b1;
			return qrs_pkg::ROOT_MAX;
		end
		if (q < -64'sd2147483648) begin
			ovf = 1'b1;
			return qrs_pkg::ROOT_MIN;
		end
		return q[31:0];
	endfunction

	function automatic qrs_pkg::root_t solve_roots(qrs_pkg::coef_t c);
		qrs_pkg::root_t  r;
		longint a, b, k, disc, s, nb;
		logic   ovf;
		a = c.coef_quad;
		b = c.coef_lin;
		k = c.coef_const;
		ovf = 1'b0;
		r = '0;
		if (a == 0) begin
			r.root_case = qrs_pkg::CASE_LEAD_ZERO;
		end else begin
			disc = b * b - 4 * a * k;
			if (disc < 0) begin
				r.root_case = qrs_pkg::CASE_NONE;
			end else begin
				nb = -b * 256;
				s = 0;
				if (disc == 0) begin
					r.root_case = qrs_pkg::CASE_DOUBLE;
				end else begin
					r.root_case = qrs_pkg::CASE_DISTINCT;
					s = longint'(floor_sqrt(64'(disc) * 64'd65536));
				end
				r.first_root = clamp_root(nb - s, a, ovf);
				r.second_root = clamp_root(nb + s, a, ovf);
			end
		end
		r.overflow = ovf;
		return r;
	endfunction

	task automatic send_request(logic signed [15:0] a, logic signed [15:0] b,
			logic signed [15:0] c);
		qrs_pkg::coef_t item;
		int gap;
		item.coef_quad = a;
		item.coef_lin = b;
		item.coef_const = c;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			coef_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coef_valid <= 1'b1;
		coef <= item;
		@(posedge clk);
		while (coef_stall)
			@(posedge clk);
		roots_due = {roots_due, solve_roots(item)};
	endtask

	function automatic logic signed [15:0] rand_coef();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 65535));
			1: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
			2: return $signed(16'($urandom_range(0, 31))) - 16'sd16;
			3: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
		endcase
	endfunction

	task automatic test_directed();
		logic signed [15:0] ext[4];
		ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
		send_request(16'sh0000, 16'sh0100, 16'sh0100);
		send_request(16'sh0100, 16'sh0000, 16'sh0100);
		send_request(16'sh0100, 16'sh0200, 16'sh0100);
		send_request(16'sh0100, 16'sh0000, -16'sh0400);
		send_request(16'sh0001, 16'sh7fff, 16'sh0000);
		send_request(16'sh0001, 16'sh0000, 16'sh8000);
		foreach (ext[i])
			foreach (ext[j])
				send_request(ext[i], ext[j], ext[(i + j) % 4]);
		send_request(16'sh5555, 16'shaaaa, 16'sh5555);
		send_request(16'shaaaa, 16'sh5555, 16'shaaaa);
	endtask

	task automatic test_double_roots();
		logic signed [15:0] a, r, sgn;
		repeat (100) begin
			sgn = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
			a = $signed(16'($urandom_range(1, 64))) * sgn;
			r = $signed(16'($urandom_range(0, 8)));
			sgn = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
			send_request(a, 16'sd2 * r * a * sgn, r * r * a);
			send_request(a, 16'($urandom_range(0, 1) ? 2 : -2) * 16'(a), a);
		end
	endtask

	task automatic test_random(int count);
		repeat (count)
			send_request(rand_coef(), rand_coef(), rand_coef());
	endtask

	task automatic test_back_pressure();
		hold_cycles = 200;
		hold_off <= 1'b1;
		test_random(150);
	endtask

	always @(posedge clk) begin
		if (hold_off) begin
			if (hold_cycles == 0)
				hold_off <= 1'b0;
			else
				hold_cycles <= hold_cycles - 1;
		end
	end

	initial begin
		int burst;
		root_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				root_stall <= 1'b1;
			end else if (!quiet && burst == 0 && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 5);
				root_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				root_stall <= (burst != 0);
			end else begin
				root_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		qrs_pkg::root_t want;
		if (arst_n && root_valid && !root_stall) begin
			if (roots_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", root);
			end else begin
				want = roots_due.pop_front();
				if (root.first_root !== want.first_root
						|| root.second_root !== want.second_root
						|| root.root_case !== want.root_case
						|| root.overflow !== want.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected %0d %0d case %0d ovf %0d, ",
							"got %0d %0d case %0d ovf %0d"},
							want.first_root, want.second_root, want.root_case,
							want.overflow, root.first_root, root.second_root,
							root.root_case, root.overflow);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		coef_valid = 1'b0;
		coef = '0;
		mismatches = 0;
		quiet = 1'b0;
		hold_off = 1'b0;
		hold_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_double_roots();
		test_back_pressure();
		test_random(1226);
		quiet = 1'b1;
		test_random(200);
		coef_valid <= 1'b0;
		waited = 0;
		while (roots_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (80) @(posedge clk);
		if (mismatches == 0 && roots_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
